FILE: src/ots_pkg.sv
// ----------------------------------------------------------------------------
// ots_pkg
// Shared types and constants for the Otsu threshold select block.
// ----------------------------------------------------------------------------
package ots_pkg;

	localparam int unsigned LEVELS = 256;
	localparam int unsigned LEVEL_BITS = 8;

	typedef enum logic [1:0] {
		MUL_DD,
		MUL_X1,
		MUL_X2
	} mul_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     pix_en;
		logic     hist_clr;
		logic     hist_rd;
		logic     lvl_inc;
		logic     sweep_init;
		logic     acc;
		logic     prod;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     cap_dd;
		logic     cap_x1;
		logic     best_upd;
		logic     div_start;
		logic     out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic lvl_last;
		logic c_edge;
		logic mul_busy;
		logic div_busy;
		logic better;
	} sts_t;

endpackage

FILE: src/ots_hist.sv
// ----------------------------------------------------------------------------
// ots_hist
// 256-bin histogram memory with a registered read-modify-write per pixel and
// a bypass for back-to-back hits on the same bin.
// ----------------------------------------------------------------------------
module ots_hist #(
	parameter int unsigned NW = 21
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_en,
	input  logic [ots_pkg::LEVEL_BITS-1:0]    pixel,
	input  logic                              clr_en,
	input  logic                              rd_en,
	input  logic [ots_pkg::LEVEL_BITS-1:0]    lvl,
	output logic [NW-1:0]                     rd_data
);

	logic [NW-1:0]                  mem [ots_pkg::LEVELS];
	logic [NW-1:0]                  rd_q;
	logic [NW-1:0]                  wr_q;
	logic [ots_pkg::LEVEL_BITS-1:0] addr_s1;
	logic                           v_s1;
	logic                           fwd_s1;
	logic [NW-1:0]                  inc;
	logic                           we;
	logic [ots_pkg::LEVEL_BITS-1:0] wa;
	logic [NW-1:0]                  wd;
	logic                           re;
	logic [ots_pkg::LEVEL_BITS-1:0] ra;

	// take the value just written when the same bin comes again
	assign inc = (fwd_s1 ? wr_q : rd_q) + NW'(1);
	assign we  = clr_en | v_s1;
	assign wa  = clr_en ? lvl : addr_s1;
	assign wd  = clr_en ? '0 : inc;
	assign re  = pix_en | rd_en;
	assign ra  = pix_en ? pixel : lvl;
	assign rd_data = rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
		if (v_s1) begin
			wr_q <= inc;
		end
		if (pix_en) begin
			addr_s1 <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= pix_en;
			fwd_s1 <= pix_en & v_s1 & (pixel == addr_s1);
		end
	end

endmodule

FILE: src/ots_mul.sv
// ----------------------------------------------------------------------------
// ots_mul
// Shift-add multiplier, one multiplier bit per cycle, stops early once the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module ots_mul #(
	parameter int unsigned AW = 68,
	parameter int unsigned BW = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             busy,
	output logic [AW+BW-1:0] prod
);

	localparam int unsigned PW = AW + BW;

	logic [PW-1:0] acc_q;
	logic [PW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic          busy_q;

	assign busy = busy_q;
	assign prod = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= PW'(a);
			b_q   <= b;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (b_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

endmodule

FILE: src/ots_div.sv
// ----------------------------------------------------------------------------
// ots_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ots_div #(
	parameter int unsigned NUMW = 68,
	parameter int unsigned DENW = 42
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic            busy,
	output logic [NUMW-1:0] quot
);

	localparam int unsigned CW = $clog2(NUMW + 1);

	logic [NUMW-1:0] num_q;
	logic [NUMW-1:0] quot_q;
	logic [DENW-1:0] den_q;
	logic [DENW-1:0] rem_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [DENW:0]   trial;
	logic            fits;

	assign trial = {rem_q, num_q[NUMW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign busy  = busy_q;
	assign quot  = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? DENW'(trial - {1'b0, den_q}) : DENW'(trial);
			num_q  <= num_q << 1;
			quot_q <= {quot_q[NUMW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUMW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/ots_dp.sv
// ----------------------------------------------------------------------------
// ots_dp
// Datapath: pixel counting, level sweep arithmetic, exact score compare by
// cross products, final score division and result registers.
// ----------------------------------------------------------------------------
module ots_dp #(
	parameter int unsigned COUNT_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ots_pkg::cmd_t                  cmd,
	output ots_pkg::sts_t                  sts,
	input  logic [ots_pkg::LEVEL_BITS-1:0] pixel,
	output logic [7:0]                     threshold,
	output logic [53:0]                    score,
	output logic [20:0]                    pixel_count,
	output logic                           overflow
);

	localparam int unsigned NW   = COUNT_BITS + 1;
	localparam int unsigned TW   = COUNT_BITS + 9;
	localparam int unsigned DW   = TW + NW;
	localparam int unsigned QW   = 2 * NW;
	localparam int unsigned DDW  = 2 * DW;
	localparam int unsigned PW   = DDW + DW;
	localparam int unsigned SXW  = DDW + 54;
	localparam int unsigned CXW  = NW + 21;

	logic [NW-1:0]                  cnt_q;
	logic [TW-1:0]                  tot_q;
	logic                           ovf_q;
	logic [ots_pkg::LEVEL_BITS-1:0] lvl_q;
	logic [NW-1:0]                  c_q;
	logic [TW-1:0]                  m_q;
	logic [DW-1:0]                  a_q;
	logic [DW-1:0]                  b_q;
	logic [QW-1:0]                  q_q;
	logic [DDW-1:0]                 dd_q;
	logic [PW-1:0]                  x1_q;
	logic [DDW-1:0]                 best_dd_q;
	logic [QW-1:0]                  best_q_q;
	logic [7:0]                     best_lvl_q;
	logic [NW-1:0]                  h;
	logic                           counted;
	logic [DW-1:0]                  d;
	logic [DDW-1:0]                 mul_a;
	logic [DW-1:0]                  mul_b;
	logic                           mul_busy;
	logic [PW-1:0]                  mul_prod;
	logic                           div_busy;
	logic [DDW-1:0]                 quot;
	logic [SXW-1:0]                 score_ext;
	logic [CXW-1:0]                 cnt_ext;

	// capacity reached once the top count bit is set
	assign counted = cmd.pix_en & ~cnt_q[COUNT_BITS];
	assign d = (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
	assign score_ext = SXW'(quot);
	assign cnt_ext   = CXW'(cnt_q);

	ots_hist #(.NW(NW)) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_en  (counted),
		.pixel   (pixel),
		.clr_en  (cmd.hist_clr),
		.rd_en   (cmd.hist_rd),
		.lvl     (lvl_q),
		.rd_data (h)
	);

	always_comb begin
		unique case (cmd.mul_sel)
			ots_pkg::MUL_DD: begin
				mul_a = DDW'(d);
				mul_b = d;
			end
			ots_pkg::MUL_X1: begin
				mul_a = dd_q;
				mul_b = DW'(best_q_q);
			end
			ots_pkg::MUL_X2: begin
				mul_a = best_dd_q;
				mul_b = DW'(q_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ots_mul #(.AW(DDW), .BW(DW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	ots_div #(.NUMW(DDW), .DENW(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (best_dd_q),
		.den    (best_q_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign sts.lvl_last = (lvl_q == ots_pkg::LEVEL_BITS'(ots_pkg::LEVELS - 1));
	assign sts.c_edge   = (c_q == '0) || (c_q == cnt_q);
	assign sts.mul_busy = mul_busy;
	assign sts.div_busy = div_busy;
	assign sts.better   = x1_q > mul_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			tot_q <= '0;
			ovf_q <= 1'b0;
			lvl_q <= '0;
		end else begin
			if (cmd.out_load) begin
				cnt_q <= '0;
				tot_q <= '0;
				ovf_q <= 1'b0;
			end else if (counted) begin
				cnt_q <= cnt_q + NW'(1);
				tot_q <= tot_q + TW'(pixel);
			end else if (cmd.pix_en) begin
				ovf_q <= 1'b1;
			end
			if (cmd.sweep_init) begin
				lvl_q <= '0;
			end else if (cmd.lvl_inc) begin
				lvl_q <= lvl_q + ots_pkg::LEVEL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_init) begin
			c_q        <= '0;
			m_q        <= '0;
			best_dd_q  <= '0;
			best_q_q   <= QW'(1);
			best_lvl_q <= '0;
		end else begin
			if (cmd.acc) begin
				c_q <= c_q + h;
				m_q <= m_q + TW'(h) * TW'(lvl_q);
			end
			if (cmd.best_upd) begin
				best_dd_q  <= dd_q;
				best_q_q   <= q_q;
				best_lvl_q <= lvl_q;
			end
		end
		if (cmd.prod) begin
			a_q <= DW'(tot_q) * DW'(c_q);
			b_q <= DW'(m_q) * DW'(cnt_q);
			q_q <= QW'(c_q) * QW'(cnt_q - c_q);
		end
		if (cmd.cap_dd) begin
			dd_q <= mul_prod[DDW-1:0];
		end
		if (cmd.cap_x1) begin
			x1_q <= mul_prod;
		end
		if (cmd.out_load) begin
			threshold   <= best_lvl_q;
			score       <= score_ext[53:0];
			pixel_count <= cnt_ext[20:0];
			overflow    <= ovf_q;
		end
	end

endmodule

FILE: src/ots_ctrl.sv
// ----------------------------------------------------------------------------
// ots_ctrl
// Sequencer: reset clear pass, pixel intake, level sweep, final divide and
// result handshake.
// ----------------------------------------------------------------------------
module ots_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          last,
	output logic          out_valid,
	input  logic          out_ready,
	output ots_pkg::cmd_t cmd,
	input  ots_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_DRAIN,
		S_RD,
		S_ACC,
		S_PROD,
		S_MDD,
		S_WDD,
		S_MX1,
		S_WX1,
		S_MX2,
		S_WX2,
		S_NEXT,
		S_DIV,
		S_WDIV,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load_ok   = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.mul_sel = ots_pkg::MUL_DD;
		cmd.pix_en  = in_valid && (state_q == S_IDLE);
		unique case (state_q)
			S_CLR: begin
				cmd.hist_clr = 1'b1;
				cmd.lvl_inc  = 1'b1;
			end
			S_DRAIN: cmd.sweep_init = 1'b1;
			S_RD: begin
				cmd.hist_rd  = 1'b1;
				cmd.hist_clr = 1'b1;
			end
			S_ACC:  cmd.acc = 1'b1;
			S_PROD: cmd.prod = !sts.c_edge;
			S_MDD: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = ots_pkg::MUL_DD;
			end
			S_WDD:  cmd.cap_dd = !sts.mul_busy;
			S_MX1: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = ots_pkg::MUL_X1;
			end
			S_WX1:  cmd.cap_x1 = !sts.mul_busy;
			S_MX2: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = ots_pkg::MUL_X2;
			end
			S_WX2:  cmd.best_upd = !sts.mul_busy && sts.better;
			S_NEXT: cmd.lvl_inc = 1'b1;
			S_DIV:  cmd.div_start = 1'b1;
			S_OUT:  cmd.out_load = load_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && load_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (sts.lvl_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid && last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_RD;
				S_RD:    state_q <= sts.lvl_last ? S_DIV : S_ACC;
				S_ACC:   state_q <= S_PROD;
				S_PROD:  state_q <= sts.c_edge ? S_NEXT : S_MDD;
				S_MDD:   state_q <= S_WDD;
				S_WDD: begin
					if (!sts.mul_busy) begin
						state_q <= S_MX1;
					end
				end
				S_MX1:   state_q <= S_WX1;
				S_WX1: begin
					if (!sts.mul_busy) begin
						state_q <= S_MX2;
					end
				end
				S_MX2:   state_q <= S_WX2;
				S_WX2: begin
					if (!sts.mul_busy) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT:  state_q <= S_RD;
				S_DIV:   state_q <= S_WDIV;
				S_WDIV: begin
					if (!sts.div_busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

endmodule

FILE: src/otsu_threshold_select.sv
// ----------------------------------------------------------------------------
// otsu_threshold_select
// Otsu threshold selection over an 8-bit, 256-bin image histogram.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle into the histogram, while in_ready is high,
// until the item marked last; up to 2**COUNT_BITS pixels are counted and
// the rest only set the overflow flag. After the last pixel the block stops
// taking pixels and sweeps levels 0..254, one level at a time: a level with
// a trivial split passes through the read, accumulate, product and next
// states, a level with a non-trivial split also makes three runs of a shared
// shift-add multiplier (one multiplier bit per cycle), and the winner's
// score is then formed by a restoring divider. After reset the block clears
// every histogram bin before it takes the first pixel; later images are
// cleared during the sweep. A finished result waits in its output register
// while the next image streams in.
// ----------------------------------------------------------------------------
module otsu_threshold_select #(
	parameter int unsigned COUNT_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pixel,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  threshold,
	output logic [53:0] score,
	output logic [20:0] pixel_count,
	output logic        overflow
);

	ots_pkg::cmd_t cmd;
	ots_pkg::sts_t sts;

	ots_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ots_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.pixel       (pixel),
		.threshold   (threshold),
		.score       (score),
		.pixel_count (pixel_count),
		.overflow    (overflow)
	);

endmodule

FILE: tb/otsu_threshold_select_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// otsu_threshold_select_tb
// Streams images of 8-bit pixels into the Otsu threshold selector and checks
// every result against an exact integer recomputation of the best split.
// ----------------------------------------------------------------------------
module otsu_threshold_select_tb;

	localparam int unsigned COUNT_BITS = 20;
	localparam longint unsigned CAPACITY = 64'd1 << COUNT_BITS;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct {
		logic [7:0] pix;
		logic       lst;
		logic       hold;
	} pixel_item_t;

	typedef struct {
		logic [7:0]  threshold;
		logic [53:0] score;
		logic [20:0] pixel_count;
		logic        overflow;
	} otsu_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  pixel = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  threshold;
	logic [53:0] score;
	logic [20:0] pixel_count;
	logic        overflow;

	pixel_item_t  pending_q[$];
	otsu_result_t expected_q[$];
	int           errors = 0;
	bit           quiet = 1'b0;
	int           send_gap = 0;
	int           recv_gap = 0;
	int           stall_cycles = 0;

	longint unsigned bin_count[ots_pkg::LEVELS];
	longint unsigned pixels_taken;
	longint unsigned value_sum;
	bit              pixels_dropped;

	otsu_threshold_select #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .pixel(pixel), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.threshold(threshold), .score(score), .pixel_count(pixel_count),
		.overflow(overflow)
	);

	always #6 clk = ~clk;

	function automatic void clear_histogram();
		foreach (bin_count[i]) bin_count[i] = 0;
		pixels_taken = 0;
		value_sum = 0;
		pixels_dropped = 1'b0;
	endfunction

	// Count one pixel; on the last one sweep the levels and queue the split.
	function automatic void absorb_pixel(logic [7:0] pix, logic lst);
		longint unsigned c, m, n, t, a, b, d, q, s, r;
		longint unsigned best_s, best_r, best_q;
		logic [127:0] sq;
		int best_level;
		otsu_result_t res;
		c = 0; m = 0;
		best_s = 0; best_r = 0; best_q = 1; best_level = 0;
		if (pixels_taken < CAPACITY) begin
			bin_count[pix]++;
			pixels_taken++;
			value_sum += pix;
		end else begin
			pixels_dropped = 1'b1;
		end
		if (!lst)
			return;
		n = pixels_taken;
		t = value_sum;
		for (int i = 0; i < ots_pkg::LEVELS - 1; i++) begin
			s = 0; r = 0; q = 1;
			c += bin_count[i];
			m += bin_count[i] * i;
			if (c != 0 && c != n) begin
				a = t * c;
				b = m * n;
				d = (a > b) ? a - b : b - a;
				q = c * (n - c);
				sq = 128'(d) * 128'(d);
				s = 64'(sq / 128'(q));
				r = 64'(sq % 128'(q));
			end
			if (i == 0 || s > best_s || (s == best_s &&
					128'(r) * 128'(best_q) > 128'(best_r) * 128'(q))) begin
				best_s = s; best_r = r; best_q = q; best_level = i;
			end
		end
		res.threshold = best_level[7:0];
		res.score = best_s[53:0];
		res.pixel_count = n[20:0];
		res.overflow = pixels_dropped;
		expected_q.insert(expected_q.size(), res);
		clear_histogram();
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	function automatic void add_pixel(int pix, bit lst, bit hold = 1'b0);
		pixel_item_t it;
		it.pix = pix[7:0];
		it.lst = lst;
		it.hold = hold;
		pending_q.insert(pending_q.size(), it);
	endfunction

	// Driver: hold the item until accepted, insert idle bursts between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel <= '0;
			last <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				absorb_pixel(pixel, last);
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_q.size() != 0 &&
					(!pending_q[0].hold || expected_q.size() == 0)) begin
				if (!quiet && $urandom_range(0, 15) == 0) begin
					send_gap <= $urandom_range(0, 11);
					in_valid <= 1'b0;
				end else begin
					pixel <= pending_q[0].pix;
					last <= pending_q[0].lst;
					in_valid <= 1'b1;
					void'(pending_q.pop_front());
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: random stalls on out_ready, compare every accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected result, threshold", threshold, 0);
				end else begin
					otsu_result_t want;
					want = expected_q.pop_front();
					if (threshold !== want.threshold)
						report("threshold", threshold, want.threshold);
					if (score !== want.score)
						report("score", score, want.score);
					if (pixel_count !== want.pixel_count)
						report("pixel_count", pixel_count, want.pixel_count);
					if (overflow !== want.overflow)
						report("overflow", overflow, want.overflow);
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				recv_gap <= $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles without any handshake once reset is released.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int len;
		int mode;
		int lo_v;
		int hi_v;
		clear_histogram();

		// Directed: single pixels at both extremes, flat images, ties.
		add_pixel(0, 1);
		add_pixel(255, 1);
		add_pixel(0, 0); add_pixel(255, 1);
		add_pixel(7, 0); add_pixel(7, 0); add_pixel(7, 1);
		add_pixel(0, 0); add_pixel(2, 1);
		add_pixel(10, 0); add_pixel(20, 0); add_pixel(30, 1);
		add_pixel(254, 0); add_pixel(255, 0); add_pixel(1, 0); add_pixel(0, 1);
		add_pixel(128, 0); add_pixel(127, 0); add_pixel(85, 0); add_pixel(170, 1);
		add_pixel(255, 0); add_pixel(255, 1, 1'b1);

		// Random images, mostly short: uniform, two-valued or drawn from a range.
		for (int items = 0; items < 900; ) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 30);
			mode = $urandom_range(0, 3);
			lo_v = $urandom_range(0, 200);
			hi_v = $urandom_range(lo_v, 255);
			for (int k = 0; k < len; k++) begin
				case (mode)
					0: add_pixel($urandom_range(0, 255), k == len - 1);
					1: add_pixel($urandom_range(0, 1) ? lo_v : hi_v, k == len - 1);
					default: add_pixel($urandom_range(lo_v, hi_v), k == len - 1,
						k == 0 && $urandom_range(0, 19) == 0);
				endcase
			end
			items += len;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_q.size() < 100);
		quiet = 1'b1;
		wait (pending_q.size() == 0);
		@(posedge clk);
		while (in_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
